[rtl/kvp_pkg.sv]
// Shared types and constants for the key-value command line parser.
// No dependencies; imported by kvp_core, kvp_out_reg and kv_command_line_parser.
`timescale 1ns / 1ps
`default_nettype none

package kvp_pkg;

	localparam int KeyLenW = 9;
	localparam int ValLenW = 14;
	localparam int MaxKeyW = 8;
	localparam int MaxValW = 13;
	localparam int CfgDataW = 13;

	// parse phases
	localparam logic [2:0] PH_LEAD      = 3'd0;
	localparam logic [2:0] PH_WORD      = 3'd1;
	localparam logic [2:0] PH_PRE_KEY   = 3'd2;
	localparam logic [2:0] PH_KEY       = 3'd3;
	localparam logic [2:0] PH_PRE_VALUE = 3'd4;
	localparam logic [2:0] PH_VALUE     = 3'd5;
	localparam logic [2:0] PH_DRAIN     = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNKNOWN  = 3'd1;
	localparam logic [2:0] ST_NO_KEY   = 3'd2;
	localparam logic [2:0] ST_KEY_LONG = 3'd3;
	localparam logic [2:0] ST_NO_VALUE = 3'd4;
	localparam logic [2:0] ST_VAL_LONG = 3'd5;
	localparam logic [2:0] ST_EXTRA    = 3'd6;

	// command codes
	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_GET  = 3'd1;
	localparam logic [2:0] CMD_SET  = 3'd2;
	localparam logic [2:0] CMD_DEL  = 3'd3;
	localparam logic [2:0] CMD_BYE  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_KEY     = 2'd0;
	localparam logic [1:0] KIND_VALUE   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// configuration register indexes
	localparam logic REG_MAX_KEY = 1'b0;
	localparam logic REG_MAX_VAL = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef struct packed {
		logic               valid;
		logic [1:0]         kind;
		logic [7:0]         data_byte;
		logic [2:0]         command_code;
		logic [2:0]         status;
		logic [KeyLenW-1:0] key_length;
		logic [ValLenW-1:0] value_length;
	} kvp_result_t;

	// keyword letters: get, set, del, bye
	function automatic logic [7:0] kw_char(input logic [1:0] word, input logic [1:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case ({word, pos})
			4'b00_00: ch = "g";
			4'b00_01: ch = "e";
			4'b00_10: ch = "t";
			4'b01_00: ch = "s";
			4'b01_01: ch = "e";
			4'b01_10: ch = "t";
			4'b10_00: ch = "d";
			4'b10_01: ch = "e";
			4'b10_10: ch = "l";
			4'b11_00: ch = "b";
			4'b11_01: ch = "y";
			4'b11_10: ch = "e";
			default:  ch = 8'h00;
		endcase
		return ch;
	endfunction

	// fold A..Z only
	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? (c + 8'd32) : c;
	endfunction

endpackage

`default_nettype wire

[rtl/kvp_core.sv]
// Parse state and per-character next-state / result logic.
// Depends on kvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvp_core
	import kvp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         char_in,
	input  wire logic [MaxKeyW-1:0] max_key_q,
	input  wire logic [MaxValW-1:0] max_val_q,
	output kvp_result_t             result
);

	logic [2:0]         phase_q;
	logic [3:0]         match_q;
	logic [2:0]         wlen_q;
	logic [2:0]         cmd_q;
	logic [KeyLenW-1:0] kcnt_q;
	logic [ValLenW-1:0] vcnt_q;
	logic [2:0]         err_q;

	logic [2:0]         phase_d;
	logic [3:0]         match_d;
	logic [2:0]         wlen_d;
	logic [2:0]         cmd_d;
	logic [KeyLenW-1:0] kcnt_d;
	logic [ValLenW-1:0] vcnt_d;
	logic [2:0]         err_d;

	logic [7:0]         lc;
	logic [3:0]         match_w;
	logic [2:0]         wlen_w;
	logic               word_ok;
	logic [2:0]         rcmd;
	logic [2:0]         rphase;
	logic [2:0]         rerr;
	logic               key_full;
	logic               val_full;
	logic [KeyLenW-1:0] key_sat;
	logic [ValLenW-1:0] val_sat;

	function automatic logic [2:0] final_status(input logic [2:0] err, input logic [2:0] ph,
		input logic [2:0] cmd);
		logic [2:0] st;
		st = err;
		if (err == ST_OK) begin
			if (ph == PH_LEAD)
				st = ST_UNKNOWN;
			else if (ph == PH_PRE_KEY)
				st = ST_NO_KEY;
			else if ((ph == PH_KEY || ph == PH_PRE_VALUE) && cmd == CMD_SET)
				st = ST_NO_VALUE;
		end
		return st;
	endfunction

	// word letter matching
	always_comb begin
		lc = fold_lower(char_in);
		match_w = match_q;
		if (wlen_q < 3'd3) begin
			for (int k = 0; k < 4; k++) begin
				if (kw_char(2'(k), wlen_q[1:0]) != lc)
					match_w[k] = 1'b0;
			end
		end else begin
			match_w = 4'b0000;
		end
		wlen_w = (wlen_q < 3'd4) ? (wlen_q + 3'd1) : wlen_q;
	end

	// word resolution on the delimiter
	always_comb begin
		word_ok = (wlen_q == 3'd3) && (match_q != 4'b0000);
		if (match_q[0])
			rcmd = CMD_GET;
		else if (match_q[1])
			rcmd = CMD_SET;
		else if (match_q[2])
			rcmd = CMD_DEL;
		else
			rcmd = CMD_BYE;
		if (!word_ok)
			rcmd = cmd_q;
		rphase = !word_ok ? PH_DRAIN : ((rcmd == CMD_BYE) ? PH_PRE_VALUE : PH_PRE_KEY);
		rerr = (!word_ok && err_q == ST_OK) ? ST_UNKNOWN : err_q;
	end

	always_comb begin
		key_full = kcnt_q >= {1'b0, max_key_q};
		val_full = vcnt_q >= {1'b0, max_val_q};
		key_sat  = {1'b0, max_key_q} + 9'd1;
		val_sat  = {1'b0, max_val_q} + 14'd1;
	end

	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		wlen_d  = wlen_q;
		cmd_d   = cmd_q;
		kcnt_d  = kcnt_q;
		vcnt_d  = vcnt_q;
		err_d   = err_q;
		result  = '0;

		// per-phase handling of one character
		case (phase_q)
			PH_LEAD: begin
				if (char_in == CHAR_NUL) begin
					result.valid = 1'b1;
					result.status = final_status(err_q, phase_q, cmd_q);
				end else if (char_in != CHAR_SPACE) begin
					phase_d = PH_WORD;
					match_d = match_w;
					wlen_d  = wlen_w;
				end
			end
			PH_WORD: begin
				if (char_in == CHAR_SPACE || char_in == CHAR_NUL) begin
					phase_d = rphase;
					cmd_d   = rcmd;
					err_d   = rerr;
					if (char_in == CHAR_NUL) begin
						result.valid = 1'b1;
						result.command_code = rcmd;
						result.status = final_status(rerr, rphase, rcmd);
					end
				end else begin
					match_d = match_w;
					wlen_d  = wlen_w;
				end
			end
			PH_PRE_KEY, PH_KEY: begin
				if (char_in == CHAR_NUL) begin
					result.valid = 1'b1;
					result.command_code = cmd_q;
					result.status = final_status(err_q, phase_q, cmd_q);
					result.key_length = kcnt_q;
				end else if (char_in == CHAR_SPACE) begin
					if (phase_q == PH_KEY)
						phase_d = PH_PRE_VALUE;
				end else if (key_full) begin
					kcnt_d  = key_sat;
					phase_d = PH_DRAIN;
					if (err_q == ST_OK)
						err_d = ST_KEY_LONG;
				end else begin
					phase_d = PH_KEY;
					kcnt_d  = kcnt_q + 9'd1;
					result.valid = 1'b1;
					result.kind = KIND_KEY;
					result.data_byte = char_in;
				end
			end
			PH_PRE_VALUE, PH_VALUE: begin
				if (char_in == CHAR_NUL) begin
					result.valid = 1'b1;
					result.command_code = cmd_q;
					result.status = final_status(err_q, phase_q, cmd_q);
					result.key_length = kcnt_q;
					result.value_length = vcnt_q;
				end else if (phase_q == PH_PRE_VALUE && char_in == CHAR_SPACE) begin
					phase_d = phase_q;
				end else if (phase_q == PH_PRE_VALUE && cmd_q != CMD_SET) begin
					phase_d = PH_DRAIN;
					if (err_q == ST_OK)
						err_d = ST_EXTRA;
				end else if (val_full) begin
					vcnt_d  = val_sat;
					phase_d = PH_DRAIN;
					if (err_q == ST_OK)
						err_d = ST_VAL_LONG;
				end else begin
					phase_d = PH_VALUE;
					vcnt_d  = vcnt_q + 14'd1;
					result.valid = 1'b1;
					result.kind = KIND_VALUE;
					result.data_byte = char_in;
				end
			end
			default: begin
				if (char_in == CHAR_NUL) begin
					result.valid = 1'b1;
					result.command_code = cmd_q;
					result.status = final_status(err_q, phase_q, cmd_q);
					result.key_length = kcnt_q;
					result.value_length = vcnt_q;
				end
			end
		endcase

		if (result.valid)
			result.kind = (result.kind == KIND_KEY && result.data_byte == CHAR_NUL &&
				char_in == CHAR_NUL) ? KIND_VERDICT : result.kind;

		// verdict returns to idle
		if (char_in == CHAR_NUL) begin
			phase_d = PH_LEAD;
			match_d = 4'b1111;
			wlen_d  = 3'd0;
			cmd_d   = CMD_NONE;
			kcnt_d  = '0;
			vcnt_d  = '0;
			err_d   = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			match_q <= 4'b1111;
			wlen_q  <= 3'd0;
			cmd_q   <= CMD_NONE;
			kcnt_q  <= '0;
			vcnt_q  <= '0;
			err_q   <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_d;
			match_q <= match_d;
			wlen_q  <= wlen_d;
			cmd_q   <= cmd_d;
			kcnt_q  <= kcnt_d;
			vcnt_q  <= vcnt_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

[rtl/kvp_out_reg.sv]
// Result register between the parse logic and the output channel.
// Depends on kvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvp_out_reg
	import kvp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  kvp_result_t      result,
	output logic             out_valid,
	input  wire logic        out_ready,
	output kvp_result_t      out_res
);

	logic        out_valid_q;
	kvp_result_t res_q;

	// take a new request when the register is empty or being drained
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid && result.valid) begin
			res_q <= result;
		end
	end

endmodule

`default_nettype wire

[rtl/kv_command_line_parser.sv]
// Top level of the key-value command line parser: limit registers,
// parse core and result register. Depends on kvp_pkg, kvp_core, kvp_out_reg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_ready   | char_in
//   output   | out_valid / out_ready | kind, data_byte, command_code, status,
//            |                       | key_length, value_length
//   config   | cfg_wr_en             | cfg_index, cfg_data
//
// One character per cycle while in_ready; a result appears in the next cycle.
// in_ready is low only while a result is held and out_ready is low.
// Reset clears the parse state and loads limits 127 and 4095.
// A character is handled entirely by the single logic stage in front of
// the result register.
`timescale 1ns / 1ps
`default_nettype none

module kv_command_line_parser
	import kvp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           char_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                kind,
	output logic [7:0]                data_byte,
	output logic [2:0]                command_code,
	output logic [2:0]                status,
	output logic [KeyLenW-1:0]        key_length,
	output logic [ValLenW-1:0]        value_length,
	input  wire logic                 cfg_wr_en,
	input  wire logic                 cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	logic [MaxKeyW-1:0] max_key_q;
	logic [MaxValW-1:0] max_val_q;
	logic               accept;
	kvp_result_t        result;
	kvp_result_t        out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_q <= 8'd127;
			max_val_q <= 13'd4095;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_KEY: max_key_q <= cfg_data[MaxKeyW-1:0];
				REG_MAX_VAL: max_val_q <= cfg_data[MaxValW-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	kvp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_in   (char_in),
		.max_key_q (max_key_q),
		.max_val_q (max_val_q),
		.result    (result)
	);

	kvp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind         = out_res.kind;
	assign data_byte    = out_res.data_byte;
	assign command_code = out_res.command_code;
	assign status       = out_res.status;
	assign key_length   = out_res.key_length;
	assign value_length = out_res.value_length;

endmodule

`default_nettype wire
